>>> rtl/assert_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define BAVG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define BAVG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/bavg_pkg.sv
package bavg_pkg;

   localparam int MAX_BLOCK_DEF   = 64;
   localparam int MAX_WIDTH_DEF   = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CSR_W       = 13;
   localparam int CSR_IDX_W   = 3;
   localparam int SIZE_W      = 7;
   localparam int FH_W        = 13;
   localparam int ENA_W       = 4;
   localparam int LANES       = 4;
   localparam int DSR_W       = 13;
   localparam int REM_W       = 14;
   localparam int POS_W       = 14;
   localparam int OFS_STEPS   = 7;
   localparam int COORD_STEPS = 14;
   localparam int CHAN_W      = 16;
   localparam int COORD_OUT_W = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_WIDTH    = 3'd0,
      CSR_BLOCK_HEIGHT   = 3'd1,
      CSR_OFFSET_X       = 3'd2,
      CSR_OFFSET_Y       = 3'd3,
      CSR_FRAME_WIDTH    = 3'd4,
      CSR_FRAME_HEIGHT   = 3'd5,
      CSR_CHANNEL_ENABLE = 3'd6,
      CSR_HAS_ALPHA      = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OFS,
      ST_SETUP,
      ST_COORD,
      ST_READ,
      ST_GATHER,
      ST_AVG,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic ofs_load;
      logic coord_load;
      logic avg_load;
      logic div_step;
      logic mem_rd;
      logic mem_wr;
      logic clr_wr;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic emit;
      logic out_free;
   } status_type;

endpackage

>>> rtl/bavg_div.sv
module bavg_div #(
   parameter int DW = 28
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          step,
   input  logic [DW-1:0]                 dvd_in [bavg_pkg::LANES],
   input  logic [bavg_pkg::DSR_W-1:0]    dsr_in [bavg_pkg::LANES],
   output logic [DW-1:0]                 quo    [bavg_pkg::LANES],
   output logic [bavg_pkg::REM_W-1:0]    rem    [bavg_pkg::LANES]
);

   // Restoring division, one quotient bit per step in every lane. The
   // dividend shifts out at the top while quotient bits shift in below.
   logic [DW-1:0]              dvd_ff [bavg_pkg::LANES];
   logic [DW-1:0]              dvd_in_s [bavg_pkg::LANES];
   logic [bavg_pkg::DSR_W-1:0] dsr_ff [bavg_pkg::LANES];
   logic [bavg_pkg::REM_W-1:0] rem_ff [bavg_pkg::LANES];
   logic [bavg_pkg::REM_W-1:0] rem_in [bavg_pkg::LANES];

   always_comb begin
      logic [bavg_pkg::REM_W-1:0] trial;
      logic [bavg_pkg::REM_W-1:0] dsr_ext;
      for (int l = 0; l < bavg_pkg::LANES; l++) begin
         trial   = {rem_ff[l][bavg_pkg::REM_W-2:0], dvd_ff[l][DW-1]};
         dsr_ext = bavg_pkg::REM_W'(dsr_ff[l]);
         if (trial >= dsr_ext) begin
            rem_in[l]   = trial - dsr_ext;
            dvd_in_s[l] = {dvd_ff[l][DW-2:0], 1'b1};
         end else begin
            rem_in[l]   = trial;
            dvd_in_s[l] = {dvd_ff[l][DW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < bavg_pkg::LANES; l++) begin
         if (load) begin
            dvd_ff[l] <= dvd_in[l];
            dsr_ff[l] <= dsr_in[l];
            rem_ff[l] <= '0;
         end else if (step) begin
            dvd_ff[l] <= dvd_in_s[l];
            rem_ff[l] <= rem_in[l];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < bavg_pkg::LANES; l++) begin
         quo[l] = dvd_ff[l];
         rem[l] = rem_ff[l];
      end
   end

endmodule

>>> rtl/bavg_ctrl.sv
module bavg_ctrl #(
   parameter int DW = 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bavg_pkg::status_type status,
   output bavg_pkg::cmd_type    cmd
);

   localparam int CNT_W = $clog2(DW);

   bavg_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bavg_pkg::ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and step counter.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         bavg_pkg::ST_CLEAR: begin
            if (status.clr_last) state_in = bavg_pkg::ST_IDLE;
         end
         bavg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bavg_pkg::ST_OFS;
               cnt_in   = CNT_W'(bavg_pkg::OFS_STEPS - 1);
            end
         end
         bavg_pkg::ST_OFS: begin
            if (cnt_ff == '0) state_in = bavg_pkg::ST_SETUP;
            else cnt_in = cnt_ff - 1'b1;
         end
         bavg_pkg::ST_SETUP: begin
            state_in = bavg_pkg::ST_COORD;
            cnt_in   = CNT_W'(bavg_pkg::COORD_STEPS - 1);
         end
         bavg_pkg::ST_COORD: begin
            if (cnt_ff == '0) state_in = bavg_pkg::ST_READ;
            else cnt_in = cnt_ff - 1'b1;
         end
         bavg_pkg::ST_READ: begin
            state_in = bavg_pkg::ST_GATHER;
         end
         bavg_pkg::ST_GATHER: begin
            if (status.emit) begin
               state_in = bavg_pkg::ST_AVG;
               cnt_in   = CNT_W'(DW - 1);
            end else begin
               state_in = bavg_pkg::ST_IDLE;
            end
         end
         bavg_pkg::ST_AVG: begin
            if (cnt_ff == '0) state_in = bavg_pkg::ST_EMIT;
            else cnt_in = cnt_ff - 1'b1;
         end
         bavg_pkg::ST_EMIT: begin
            if (status.out_free) state_in = bavg_pkg::ST_IDLE;
         end
         default: state_in = bavg_pkg::ST_CLEAR;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bavg_pkg::ST_CLEAR:  cmd.clr_wr = 1'b1;
         bavg_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.take     = req_valid;
            cmd.ofs_load = req_valid;
         end
         bavg_pkg::ST_OFS:    cmd.div_step   = 1'b1;
         bavg_pkg::ST_SETUP:  cmd.coord_load = 1'b1;
         bavg_pkg::ST_COORD:  cmd.div_step   = 1'b1;
         bavg_pkg::ST_READ:   cmd.mem_rd     = 1'b1;
         bavg_pkg::ST_GATHER: begin
            cmd.mem_wr   = 1'b1;
            cmd.avg_load = status.emit;
         end
         bavg_pkg::ST_AVG:    cmd.div_step   = 1'b1;
         bavg_pkg::ST_EMIT:   cmd.out_load   = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

>>> rtl/bavg_dp.sv
module bavg_dp #(
   parameter int MAX_WIDTH   = bavg_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = bavg_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bavg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bavg_pkg::CSR_W-1:0]          csr_wdata,
   input  logic [bavg_pkg::CHAN_W-1:0]         req_chan0,
   input  logic [bavg_pkg::CHAN_W-1:0]         req_chan1,
   input  logic [bavg_pkg::CHAN_W-1:0]         req_chan2,
   input  logic [bavg_pkg::CHAN_W-1:0]         req_chan3,
   input  logic                                req_frame_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bavg_pkg::CHAN_W-1:0]         rsp_avg0,
   output logic [bavg_pkg::CHAN_W-1:0]         rsp_avg1,
   output logic [bavg_pkg::CHAN_W-1:0]         rsp_avg2,
   output logic [bavg_pkg::CHAN_W-1:0]         rsp_avg3,
   output logic [bavg_pkg::COORD_OUT_W-1:0]    rsp_block_col,
   output logic [bavg_pkg::COORD_OUT_W-1:0]    rsp_block_row,
   output logic                                rsp_frame_done,
   input  bavg_pkg::cmd_type                   cmd,
   output bavg_pkg::status_type                status
);

   localparam int MAX_BLOCK = bavg_pkg::MAX_BLOCK_DEF;
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int SUM_W = SAMPLE_BITS + 12;
   localparam int DW    = SUM_W;
   localparam int SW    = bavg_pkg::SIZE_W;
   localparam int PW    = bavg_pkg::POS_W;
   localparam int L     = bavg_pkg::LANES;

   typedef logic [L-1:0][SUM_W-1:0] entry_type;

   // Configuration registers.
   logic [SW-1:0]                bw_ff, bh_ff, offx_ff, offy_ff;
   logic [bavg_pkg::CSR_W-1:0]   fw_ff, fh_ff;
   logic [bavg_pkg::ENA_W-1:0]   ena_ff;
   logic                         alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff    <= SW'(1);
         bh_ff    <= SW'(1);
         offx_ff  <= '0;
         offy_ff  <= '0;
         fw_ff    <= bavg_pkg::CSR_W'(1);
         fh_ff    <= bavg_pkg::CSR_W'(1);
         ena_ff   <= '1;
         alpha_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (bavg_pkg::csr_index_type'(csr_index))
            bavg_pkg::CSR_BLOCK_WIDTH:    bw_ff    <= csr_wdata[SW-1:0];
            bavg_pkg::CSR_BLOCK_HEIGHT:   bh_ff    <= csr_wdata[SW-1:0];
            bavg_pkg::CSR_OFFSET_X:       offx_ff  <= csr_wdata[SW-1:0];
            bavg_pkg::CSR_OFFSET_Y:       offy_ff  <= csr_wdata[SW-1:0];
            bavg_pkg::CSR_FRAME_WIDTH:    fw_ff    <= csr_wdata;
            bavg_pkg::CSR_FRAME_HEIGHT:   fh_ff    <= csr_wdata;
            bavg_pkg::CSR_CHANNEL_ENABLE: ena_ff   <= csr_wdata[bavg_pkg::ENA_W-1:0];
            bavg_pkg::CSR_HAS_ALPHA:      alpha_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective sizes: zero acts as one; large block sizes and frame widths saturate.
   logic [SW-1:0]              bw, bh;
   logic [XW:0]                fw;
   logic [bavg_pkg::FH_W-1:0]  fh;

   always_comb begin
      if (bw_ff == '0) bw = SW'(1);
      else if (MAX_BLOCK < 128 && int'(bw_ff) > MAX_BLOCK) bw = SW'(MAX_BLOCK);
      else bw = bw_ff;
      if (bh_ff == '0) bh = SW'(1);
      else if (MAX_BLOCK < 128 && int'(bh_ff) > MAX_BLOCK) bh = SW'(MAX_BLOCK);
      else bh = bh_ff;
      if (fw_ff == '0) fw = (XW+1)'(1);
      else if (int'(fw_ff) > MAX_WIDTH) fw = (XW+1)'(MAX_WIDTH);
      else fw = (XW+1)'(fw_ff);
      fh = (fh_ff == '0) ? bavg_pkg::FH_W'(1) : fh_ff;
   end

   // Pixel position and the accepted beat.
   logic [XW-1:0]                px_ff, px_in, x_ff, x_in;
   logic [bavg_pkg::FH_W-1:0]    py_ff, py_in, y_ff, y_in;
   logic [bavg_pkg::CHAN_W-1:0]  chan_ff [L];

   always_comb begin
      logic [XW:0]               xn;
      logic [bavg_pkg::FH_W:0]   yn;
      x_in = req_frame_start ? '0 : px_ff;
      y_in = req_frame_start ? '0 : py_ff;
      if ((XW+1)'(x_in) >= fw) begin
         x_in = '0;
         y_in = y_in + 1'b1;
      end
      if (y_in >= fh) y_in = '0;
      xn = (XW+1)'(x_in) + 1'b1;
      yn = (bavg_pkg::FH_W+1)'(y_in) + 1'b1;
      if (xn >= fw) begin
         px_in = '0;
         py_in = (yn >= (bavg_pkg::FH_W+1)'(fh)) ? '0 : yn[bavg_pkg::FH_W-1:0];
      end else begin
         px_in = xn[XW-1:0];
         py_in = y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
      end else if (cmd.take) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         chan_ff[0] <= req_chan0;
         chan_ff[1] <= req_chan1;
         chan_ff[2] <= req_chan2;
         chan_ff[3] <= req_chan3;
      end
   end

   // Shared divider lanes.
   logic [DW-1:0]              dvd_in [L];
   logic [bavg_pkg::DSR_W-1:0] dsr_in [L];
   logic [DW-1:0]              quo    [L];
   logic [bavg_pkg::REM_W-1:0] rem    [L];

   bavg_div #(.DW(DW)) u_div (
      .clock  (clock),
      .load   (cmd.ofs_load | cmd.coord_load | cmd.avg_load),
      .step   (cmd.div_step),
      .dvd_in (dvd_in),
      .dsr_in (dsr_in),
      .quo    (quo),
      .rem    (rem)
   );

   // Values read from the lanes once a pass is complete.
   logic [SW-1:0]   sx, sy, phase_x, phase_y, dx, dy;
   logic [XW-1:0]   col;
   logic [PW-1:0]   row, x_pos, y_pos;
   logic [bavg_pkg::DSR_W-1:0] scale;
   logic            fresh, end_x, end_y, last_x, last_y;

   always_comb begin
      sx      = (rem[0][SW-1:0] == '0) ? '0 : bw - rem[0][SW-1:0];
      sy      = (rem[1][SW-1:0] == '0) ? '0 : bh - rem[1][SW-1:0];
      x_pos   = PW'(x_ff) + PW'(sx);
      y_pos   = PW'(y_ff) + PW'(sy);
      phase_x = rem[0][SW-1:0];
      phase_y = rem[1][SW-1:0];
      col     = quo[0][XW-1:0];
      row     = quo[1][PW-1:0];
      dx      = (PW'(x_ff) >= PW'(phase_x)) ? phase_x : SW'(x_ff);
      dy      = (PW'(y_ff) >= PW'(phase_y)) ? phase_y : SW'(y_ff);
      fresh   = (dx == '0) && (dy == '0);
      scale   = bavg_pkg::DSR_W'(dx + 1'b1) * bavg_pkg::DSR_W'(dy + 1'b1);
      last_x  = ((XW+1)'(x_ff) == fw - 1'b1);
      last_y  = (y_ff == fh - 1'b1);
      end_x   = (phase_x == bw - 1'b1) || last_x;
      end_y   = (phase_y == bh - 1'b1) || last_y;
   end

   // Column sum store with its clearing sweep after reset.
   entry_type                  mem [MAX_WIDTH];
   entry_type                  rd_ff, wdata;
   logic [XW-1:0]              clr_addr_ff, waddr;
   logic                       wen;
   logic [L-1:0]               on;

   always_comb begin
      on = {alpha_ff & ena_ff[3], ena_ff[2:0]};
      for (int k = 0; k < L; k++) begin
         wdata[k] = (fresh ? '0 : rd_ff[k])
                  + (on[k] ? SUM_W'(chan_ff[k][SAMPLE_BITS-1:0]) : '0);
      end
      wen   = cmd.clr_wr | cmd.mem_wr;
      waddr = cmd.clr_wr ? clr_addr_ff : col;
   end

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= cmd.clr_wr ? '0 : wdata;
      if (cmd.mem_rd) rd_ff <= mem[col];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_addr_ff <= '0;
      else if (cmd.clr_wr) clr_addr_ff <= clr_addr_ff + 1'b1;
   end

   // Divider operand selection.
   always_comb begin
      for (int k = 0; k < L; k++) begin
         dvd_in[k] = '0;
         dsr_in[k] = bavg_pkg::DSR_W'(1);
      end
      priority if (cmd.ofs_load) begin
         dvd_in[0] = {offx_ff, {(DW-SW){1'b0}}};
         dvd_in[1] = {offy_ff, {(DW-SW){1'b0}}};
         dsr_in[0] = bavg_pkg::DSR_W'(bw);
         dsr_in[1] = bavg_pkg::DSR_W'(bh);
      end else if (cmd.coord_load) begin
         dvd_in[0] = {x_pos, {(DW-PW){1'b0}}};
         dvd_in[1] = {y_pos, {(DW-PW){1'b0}}};
         dsr_in[0] = bavg_pkg::DSR_W'(bw);
         dsr_in[1] = bavg_pkg::DSR_W'(bh);
      end else begin
         for (int k = 0; k < L; k++) begin
            dvd_in[k] = wdata[k];
            dsr_in[k] = scale;
         end
      end
   end

   // Block coordinates held while the averages are divided.
   logic [bavg_pkg::COORD_OUT_W-1:0] bcol_ff, brow_ff;
   logic                             done_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         bcol_ff <= bavg_pkg::COORD_OUT_W'(col);
         brow_ff <= bavg_pkg::COORD_OUT_W'(row);
         done_ff <= last_x & last_y;
      end
   end

   // Result register.
   logic                        rsp_valid_ff;
   logic [bavg_pkg::CHAN_W-1:0] avg_ff [L];
   logic [bavg_pkg::COORD_OUT_W-1:0] ocol_ff, orow_ff;
   logic                        odone_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int k = 0; k < L; k++) avg_ff[k] <= quo[k][bavg_pkg::CHAN_W-1:0];
         ocol_ff  <= bcol_ff;
         orow_ff  <= brow_ff;
         odone_ff <= done_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_avg0       = avg_ff[0];
   assign rsp_avg1       = avg_ff[1];
   assign rsp_avg2       = avg_ff[2];
   assign rsp_avg3       = avg_ff[3];
   assign rsp_block_col  = ocol_ff;
   assign rsp_block_row  = orow_ff;
   assign rsp_frame_done = odone_ff;

   assign status.clr_last = (clr_addr_ff == XW'(MAX_WIDTH - 1));
   assign status.emit     = end_x & end_y;
   assign status.out_free = ~rsp_valid_ff | rsp_ready;

endmodule

>>> rtl/block_average_downsample.sv
// Pixel beats are taken one at a time; the next waits until the shared divider is
// through with the last one and any block it closed has reached the output register.
// rsp_valid rises when the output register is loaded after the block's averaging pass.
// Reset: synchronous, active high; afterwards the column sum memory is swept to
// zero across all MAX_WIDTH columns, during which req_ready stays low.
`include "assert_macros.svh"

module block_average_downsample #(
   parameter int MAX_WIDTH   = bavg_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = bavg_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bavg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bavg_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bavg_pkg::CHAN_W-1:0]      req_chan0,
   input  logic [bavg_pkg::CHAN_W-1:0]      req_chan1,
   input  logic [bavg_pkg::CHAN_W-1:0]      req_chan2,
   input  logic [bavg_pkg::CHAN_W-1:0]      req_chan3,
   input  logic                             req_frame_start,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bavg_pkg::CHAN_W-1:0]      rsp_avg0,
   output logic [bavg_pkg::CHAN_W-1:0]      rsp_avg1,
   output logic [bavg_pkg::CHAN_W-1:0]      rsp_avg2,
   output logic [bavg_pkg::CHAN_W-1:0]      rsp_avg3,
   output logic [bavg_pkg::COORD_OUT_W-1:0] rsp_block_col,
   output logic [bavg_pkg::COORD_OUT_W-1:0] rsp_block_row,
   output logic                             rsp_frame_done
);

   // Each accepted beat runs through the shared four-lane divider two or three
   // times: first the grid offsets are reduced modulo the block size, then
   // the shifted pixel position is split into block index and phase, and
   // finally, when the pixel closes a block, the four column sums are
   // divided by the block area within the frame. The sum memory is read and
   // written once per beat in between. A finished result waits in the output
   // register so the next beat can be taken while the consumer stalls.

   bavg_pkg::cmd_type    cmd;
   bavg_pkg::status_type status;

   bavg_ctrl #(.DW(SAMPLE_BITS + 12)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bavg_dp #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_chan0       (req_chan0),
      .req_chan1       (req_chan1),
      .req_chan2       (req_chan2),
      .req_chan3       (req_chan3),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_avg0        (rsp_avg0),
      .rsp_avg1        (rsp_avg1),
      .rsp_avg2        (rsp_avg2),
      .rsp_avg3        (rsp_avg3),
      .rsp_block_col   (rsp_block_col),
      .rsp_block_row   (rsp_block_row),
      .rsp_frame_done  (rsp_frame_done),
      .cmd             (cmd),
      .status          (status)
   );

   // Right after reset no beat can be taken, as the sum memory is still being cleared.
   `BAVG_ASSERT_SAME(a_no_take_after_reset, $past(reset), !req_ready)
   // Only one pixel is in flight at a time.
   `BAVG_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
   // A result only appears after the controller loads the output register.
   `BAVG_ASSERT_SAME(a_rsp_from_load, $rose(rsp_valid), $past(cmd.out_load))

endmodule

>>> sim/tb_block_average_downsample.sv
module tb_block_average_downsample;
   timeunit 1ns;
   timeprecision 1ps;

   // Watchdog limit in cycles without any beat on either channel. The longest honest
   // quiet stretch is the column sweep after reset, so this leaves a wide margin over it
   // and over the block's latency.
   localparam int QUIET_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 80;
   localparam int ITEM_TARGET  = 1500;

   // The scoreboard carries its own copy of the register file and the column sums,
   // updates the sums on every accepted pixel beat, works out the averages when a beat
   // closes a block, and compares the result beats against the oldest waiting block.
   typedef struct {
      logic [bavg_pkg::CHAN_W-1:0]      avg [bavg_pkg::LANES];
      logic [bavg_pkg::COORD_OUT_W-1:0] col;
      logic [bavg_pkg::COORD_OUT_W-1:0] row;
      logic                             done;
   } block_result_type;

   class block_scoreboard;
      int unsigned blk_w, blk_h, ofs_x, ofs_y, frm_w, frm_h, chan_en, alpha;
      int unsigned pos_x, pos_y;
      longint unsigned  col_sum [bavg_pkg::LANES][bavg_pkg::MAX_WIDTH_DEF];
      block_result_type waiting [$];
      int               errors;

      function new();
         blk_w = 1; blk_h = 1; ofs_x = 0; ofs_y = 0;
         frm_w = 1; frm_h = 1; chan_en = 15; alpha = 0;
         pos_x = 0; pos_y = 0; errors = 0;
         foreach (col_sum[l, c]) col_sum[l][c] = 0;
      endfunction

      function void write_reg(bavg_pkg::csr_index_type idx, int unsigned val);
         case (idx)
            bavg_pkg::CSR_BLOCK_WIDTH:    blk_w = val & 32'h7f;
            bavg_pkg::CSR_BLOCK_HEIGHT:   blk_h = val & 32'h7f;
            bavg_pkg::CSR_OFFSET_X:       ofs_x = val & 32'h7f;
            bavg_pkg::CSR_OFFSET_Y:       ofs_y = val & 32'h7f;
            bavg_pkg::CSR_FRAME_WIDTH:    frm_w = val & 32'h1fff;
            bavg_pkg::CSR_FRAME_HEIGHT:   frm_h = val & 32'h1fff;
            bavg_pkg::CSR_CHANNEL_ENABLE: chan_en = val & 32'hf;
            bavg_pkg::CSR_HAS_ALPHA:      alpha = val & 32'h1;
            default: ;
         endcase
      endfunction

      static function int unsigned clamp_size(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         return (v > hi) ? hi : v;
      endfunction

      function void note_pixel(logic [bavg_pkg::CHAN_W-1:0] smp [bavg_pkg::LANES],
                               logic fs);
         int unsigned bw, bh, fw, fh, sx, sy, x, y, px, py, col, row, x1, y1;
         bit fresh, on;
         block_result_type r;
         bw = clamp_size(blk_w, bavg_pkg::MAX_BLOCK_DEF);
         bh = clamp_size(blk_h, bavg_pkg::MAX_BLOCK_DEF);
         fw = clamp_size(frm_w, bavg_pkg::MAX_WIDTH_DEF);
         fh = clamp_size(frm_h, 8191);
         sx = (bw - ofs_x % bw) % bw;
         sy = (bh - ofs_y % bh) % bh;
         if (fs) begin
            pos_x = 0; pos_y = 0;
         end
         // A shrunken frame wraps a stale position onto the next row or the top.
         if (pos_x >= fw) begin
            pos_x = 0; pos_y++;
         end
         if (pos_y >= fh) pos_y = 0;
         x = pos_x; y = pos_y;
         px = (x + sx) % bw;  py = (y + sy) % bh;
         col = (x + sx) / bw; row = (y + sy) / bh;
         x1 = (x >= px) ? x - px : 0;
         y1 = (y >= py) ? y - py : 0;
         fresh = (x == x1) && (y == y1);
         for (int l = 0; l < bavg_pkg::LANES; l++) begin
            on = (l == 3) ? (alpha != 0 && chan_en[3]) : chan_en[l];
            col_sum[l][col] = (fresh ? 0 : col_sum[l][col]) + (on ? smp[l] : 0);
         end
         pos_x = x + 1;
         if (pos_x >= fw) begin
            pos_x = 0;
            pos_y = (y + 1 >= fh) ? 0 : y + 1;
         end
         if (((px == bw - 1) || (x == fw - 1)) && ((py == bh - 1) || (y == fh - 1))) begin
            for (int l = 0; l < bavg_pkg::LANES; l++)
               r.avg[l] = bavg_pkg::CHAN_W'(col_sum[l][col] /
                                            ((x - x1 + 1) * (y - y1 + 1)));
            r.col  = col[bavg_pkg::COORD_OUT_W-1:0];
            r.row  = row[bavg_pkg::COORD_OUT_W-1:0];
            r.done = (x == fw - 1) && (y == fh - 1);
            waiting.push_back(r);
         end
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_result(block_result_type got);
         block_result_type want;
         if (waiting.size() == 0) begin
            report($sformatf("unexpected block result col %0d row %0d", got.col, got.row));
            return;
         end
         want = waiting.pop_front();
         for (int l = 0; l < bavg_pkg::LANES; l++)
            if (got.avg[l] !== want.avg[l])
               report($sformatf("avg%0d got %h want %h (col %0d row %0d)",
                                l, got.avg[l], want.avg[l], want.col, want.row));
         if (got.col !== want.col)
            report($sformatf("block_col got %0d want %0d", got.col, want.col));
         if (got.row !== want.row)
            report($sformatf("block_row got %0d want %0d", got.row, want.row));
         if (got.done !== want.done)
            report($sformatf("frame_done got %b want %b (col %0d row %0d)",
                             got.done, want.done, want.col, want.row));
      endtask
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_wr_en = 1'b0;
   logic [bavg_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [bavg_pkg::CSR_W-1:0]       csr_wdata = '0;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [bavg_pkg::CHAN_W-1:0]      req_chan0 = '0, req_chan1 = '0;
   logic [bavg_pkg::CHAN_W-1:0]      req_chan2 = '0, req_chan3 = '0;
   logic                             req_frame_start = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [bavg_pkg::CHAN_W-1:0]      rsp_avg0, rsp_avg1, rsp_avg2, rsp_avg3;
   logic [bavg_pkg::COORD_OUT_W-1:0] rsp_block_col, rsp_block_row;
   logic                             rsp_frame_done;

   block_scoreboard sb = new();
   bit  calm_tail = 1'b0;  // set for the final stretch, where nobody idles
   int  sent_pixels = 0;
   int  quiet_cycles = 0;

   always #2 clock = ~clock;

   block_average_downsample dut (.*);

   // Write one register; the caller lowers the write enable after its last write so
   // that back-to-back writes never drop and raise the enable in one step.
   task automatic csr_write(bavg_pkg::csr_index_type idx, int unsigned val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= bavg_pkg::CSR_W'(val);
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   // Present one pixel beat and hold it until the block takes it. With idling on,
   // the valid line may then drop for a random burst of cycles.
   task automatic send_pixel(logic [bavg_pkg::CHAN_W-1:0] c0, c1, c2, c3, logic fs);
      logic [bavg_pkg::CHAN_W-1:0] smp [bavg_pkg::LANES];
      smp = '{c0, c1, c2, c3};
      req_valid       <= 1'b1;
      req_chan0       <= c0;
      req_chan1       <= c1;
      req_chan2       <= c2;
      req_chan3       <= c3;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(smp, fs);
      sent_pixels++;
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // The sender holds off until every block result is back, then lets the block
   // finish any beat still in flight before the registers change.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.waiting.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_pixel(logic fs);
      send_pixel(bavg_pkg::CHAN_W'($urandom_range(0, 16'hffff)),
                 bavg_pkg::CHAN_W'($urandom_range(0, 16'hffff)),
                 bavg_pkg::CHAN_W'($urandom_range(0, 16'hffff)),
                 bavg_pkg::CHAN_W'($urandom_range(0, 16'hffff)), fs);
   endtask

   // Pick a register setting. Most are small so that blocks close often; the rest
   // hit the saturating and degenerate sizes and the large offsets.
   task automatic random_setting();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      csr_write(bavg_pkg::CSR_BLOCK_WIDTH,
                (pick == 0) ? 0 : (pick == 1) ? 64 : (pick == 2) ? 127 :
                $urandom_range(1, 6));
      pick = $urandom_range(0, 9);
      csr_write(bavg_pkg::CSR_BLOCK_HEIGHT,
                (pick == 0) ? 0 : (pick == 1) ? 64 : (pick == 2) ? 127 :
                $urandom_range(1, 5));
      csr_write(bavg_pkg::CSR_OFFSET_X,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
                $urandom_range(0, 3));
      csr_write(bavg_pkg::CSR_OFFSET_Y,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) :
                $urandom_range(0, 3));
      pick = $urandom_range(0, 19);
      csr_write(bavg_pkg::CSR_FRAME_WIDTH,
                (pick == 0) ? 0 : (pick == 1) ? 4096 : (pick == 2) ? 8191 :
                $urandom_range(1, 20));
      pick = $urandom_range(0, 19);
      csr_write(bavg_pkg::CSR_FRAME_HEIGHT,
                (pick == 0) ? 0 : (pick == 1) ? 8191 : $urandom_range(1, 10));
      csr_write(bavg_pkg::CSR_CHANNEL_ENABLE,
                ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 15);
      csr_write(bavg_pkg::CSR_HAS_ALPHA, $urandom_range(0, 1));
      csr_wr_en <= 1'b0;
   endtask

   // Stimulus: a short directed opening, then phases of random settings, each one a
   // run of raster frames with random samples and an occasional stray frame start.
   initial begin : stimulus
      int unsigned fw, fh, in_frame, len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: every pixel is its own block and its own frame.
      send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
      send_pixel(16'hffff, 16'h0000, 16'haaaa, 16'h5555, 1'b1);
      drain();

      // A 2x2 grid offset by 65 and 64 on a 3x3 frame with alpha on:
      // clipped edge blocks, a large offset and full-scale sums.
      csr_write(bavg_pkg::CSR_BLOCK_WIDTH, 2);
      csr_write(bavg_pkg::CSR_BLOCK_HEIGHT, 2);
      csr_write(bavg_pkg::CSR_OFFSET_X, 65);
      csr_write(bavg_pkg::CSR_OFFSET_Y, 64);
      csr_write(bavg_pkg::CSR_FRAME_WIDTH, 3);
      csr_write(bavg_pkg::CSR_FRAME_HEIGHT, 3);
      csr_write(bavg_pkg::CSR_CHANNEL_ENABLE, 15);
      csr_write(bavg_pkg::CSR_HAS_ALPHA, 1);
      csr_wr_en <= 1'b0;
      for (int i = 0; i < 9; i++)
         send_pixel(16'hffff, 16'hfffe, 16'h0001, 16'h8000, i == 0);
      // The frame wraps on its own; then a partial frame cut by a frame start.
      send_random_pixel(1'b0);
      send_random_pixel(1'b0);
      send_random_pixel(1'b1);
      drain();

      // Degenerate sizes with channels partly off: zero block size and zero frame.
      csr_write(bavg_pkg::CSR_BLOCK_WIDTH, 0);
      csr_write(bavg_pkg::CSR_BLOCK_HEIGHT, 127);
      csr_write(bavg_pkg::CSR_FRAME_WIDTH, 0);
      csr_write(bavg_pkg::CSR_FRAME_HEIGHT, 0);
      csr_write(bavg_pkg::CSR_CHANNEL_ENABLE, 4'b1010);
      csr_write(bavg_pkg::CSR_HAS_ALPHA, 0);
      csr_wr_en <= 1'b0;
      for (int i = 0; i < 4; i++) send_random_pixel(i[0]);
      drain();

      while (sent_pixels < ITEM_TARGET) begin
         random_setting();
         fw = block_scoreboard::clamp_size(sb.frm_w, bavg_pkg::MAX_WIDTH_DEF);
         fh = block_scoreboard::clamp_size(sb.frm_h, 8191);
         len = $urandom_range(20, 120);
         if (sent_pixels + len > ITEM_TARGET - 200) calm_tail = 1'b1;
         // Sometimes the phase carries on from the old position, which exercises a
         // setting change in the middle of a frame.
         in_frame = ($urandom_range(0, 4) == 0) ? 1 : 0;
         for (int i = 0; i < len; i++) begin
            send_random_pixel((in_frame == 0) || ($urandom_range(0, 49) == 0));
            in_frame = (in_frame + 1 >= fw * fh) ? 0 : in_frame + 1;
         end
         drain();
      end

      // The waiting queue is empty here and the block has had time to settle; anything
      // that shows up now is an extra result and is caught by the checker.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.waiting.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Result side: check each accepted result beat, then pick the next ready level.
   initial begin : result_side
      block_result_type got;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready && !reset) begin
            got.avg  = '{rsp_avg0, rsp_avg1, rsp_avg2, rsp_avg3};
            got.col  = rsp_block_col;
            got.row  = rsp_block_row;
            got.done = rsp_frame_done;
            sb.check_result(got);
         end
         if (calm_tail || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(posedge clock);
         end
      end
   end

   // Watchdog: too long without a beat on either channel means the block hung.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/bavg_pkg.sv
rtl/bavg_div.sv
rtl/bavg_ctrl.sv
rtl/bavg_dp.sv
rtl/block_average_downsample.sv
sim/tb_block_average_downsample.sv
